// ===== sv/pavg_pkg.sv =====
package pavg_pkg;

    // field widths fixed by the register map and the beat formats
    localparam int SCALE_W = 22;
    localparam int DIV_W   = 24;
    localparam int THR_W   = 16;
    localparam int MUX_W   = 24;
    localparam int PWR_W   = 16;
    localparam int SUM_W   = 32;
    localparam int SCAN_W  = 16;
    localparam int GAIN_W  = 8;
    localparam int CHAN_W  = 3;
    localparam int SEL_W   = 3;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;

    // register reset values
    localparam logic [SCALE_W-1:0] SCALE_RST = '0;
    localparam logic [DIV_W-1:0]   DIV_RST   = DIV_W'(1);
    localparam logic [THR_W-1:0]   UP_RST    = '0;
    localparam logic [THR_W-1:0]   DOWN_RST  = '1;
    localparam logic [MUX_W-1:0]   MUX_RST   = MUX_W'(14423269);

    // largest scan count before the counter folds back to one
    localparam logic [SCAN_W-1:0]  SCAN_FOLD = SCAN_W'(65534);

    // register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_SCALE = 3'd0,
        REG_DIV_HI = 3'd1,
        REG_DIV_LO = 3'd2,
        REG_UP     = 3'd3,
        REG_DOWN   = 3'd4,
        REG_MUX    = 3'd5
    } t_reg_idx;

    // item and beat codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;
    localparam logic KIND_STEP  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // configuration seen by the datapath
    typedef struct packed {
        logic [SCALE_W-1:0] scale_numerator;
        logic [DIV_W-1:0]   divisor_high_gain;
        logic [DIV_W-1:0]   divisor_low_gain;
        logic [THR_W-1:0]   switch_up_threshold;
        logic [THR_W-1:0]   switch_down_threshold;
        logic [MUX_W-1:0]   mux_map;
    } t_cfg;

endpackage

// ===== sv/pavg_div.sv =====
module pavg_div #(
    parameter int N_W = 33,
    parameter int D_W = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_done,
    output logic [N_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_num;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_den;

    logic [D_W:0]   shifted;
    logic [D_W+1:0] diff;
    logic           qbit;

    // one restoring step: bring down the next dividend bit and try the divisor
    always_comb begin
        shifted = {r_rem, r_num[N_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        qbit    = ~diff[D_W+1];
    end

    // quotient bits shift into the dividend register as its bits are consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_W);
                r_num  <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_num <= {r_num[N_W-2:0], qbit};
                r_rem <= qbit ? diff[D_W-1:0] : shifted[D_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;

endmodule

// ===== sv/pavg_cfg.sv =====
module pavg_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pavg_pkg::ADDR_W-1:0]  paddr,
    input  logic [pavg_pkg::DATA_W-1:0]  pwdata,
    output logic [pavg_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output pavg_pkg::t_cfg               o_cfg
);
    import pavg_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx   = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en = psel & penable & pwrite;

    // register writes, upper data bits dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_numerator       <= SCALE_RST;
            r_cfg.divisor_high_gain     <= DIV_RST;
            r_cfg.divisor_low_gain      <= DIV_RST;
            r_cfg.switch_up_threshold   <= UP_RST;
            r_cfg.switch_down_threshold <= DOWN_RST;
            r_cfg.mux_map               <= MUX_RST;
        end else if (wr_en) begin
            case (idx)
                REG_SCALE:  r_cfg.scale_numerator       <= pwdata[SCALE_W-1:0];
                REG_DIV_HI: r_cfg.divisor_high_gain     <= pwdata[DIV_W-1:0];
                REG_DIV_LO: r_cfg.divisor_low_gain      <= pwdata[DIV_W-1:0];
                REG_UP:     r_cfg.switch_up_threshold   <= pwdata[THR_W-1:0];
                REG_DOWN:   r_cfg.switch_down_threshold <= pwdata[THR_W-1:0];
                REG_MUX:    r_cfg.mux_map               <= pwdata[MUX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read back
    always_comb begin
        case (idx)
            REG_SCALE:  prdata = DATA_W'(r_cfg.scale_numerator);
            REG_DIV_HI: prdata = DATA_W'(r_cfg.divisor_high_gain);
            REG_DIV_LO: prdata = DATA_W'(r_cfg.divisor_low_gain);
            REG_UP:     prdata = DATA_W'(r_cfg.switch_up_threshold);
            REG_DOWN:   prdata = DATA_W'(r_cfg.switch_down_threshold);
            REG_MUX:    prdata = DATA_W'(r_cfg.mux_map);
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

// ===== sv/multichannel_autorange_power_averager.sv =====
// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_stall     i_cmd, i_adc_sample
// output    out        o_out_valid / i_out_stall   o_kind .. o_last
// config    in/out     psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// a sample item is scaled, divided on the bit-serial divider, then updates the
// gain; an item that closes a scan also adds every channel into its sum. a read
// item divides every channel sum by the scan count, then sends a frame beat per
// channel; it skips the divisions when no scan has completed. one item at a
// time: o_in_stall is high from acceptance until its last beat is in the output
// register. synchronous active-low reset clears all but payload and work regs.
module multichannel_autorange_power_averager #(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_cmd,
    input  logic [SAMPLE_BITS-1:0]        i_adc_sample,
    // beat output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_kind,
    output logic [pavg_pkg::CHAN_W-1:0]   o_channel,
    output logic [pavg_pkg::SEL_W-1:0]    o_mux_select,
    output logic [pavg_pkg::GAIN_W-1:0]   o_gain_bits,
    output logic [pavg_pkg::PWR_W-1:0]    o_average_value,
    output logic [pavg_pkg::SCAN_W-1:0]   o_scan_total,
    output logic                          o_last,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pavg_pkg::ADDR_W-1:0]   paddr,
    input  logic [pavg_pkg::DATA_W-1:0]   pwdata,
    output logic [pavg_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import pavg_pkg::*;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W = SAMPLE_BITS + SCALE_W;
    localparam int NUM_W  = (PROD_W + 1 > SUM_W) ? PROD_W + 1 : SUM_W;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_GAIN,
        S_SCAN,
        S_ACC,
        S_STEP_OUT,
        S_RD_GO,
        S_RD_WAIT,
        S_RD_DONE,
        S_FRAME_OUT
    } t_state;

    t_cfg cfg;

    pavg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    t_state                 r_state;
    logic [CH_W-1:0]        r_ch;
    logic [CH_W-1:0]        r_idx;
    logic [GAIN_W-1:0]      r_gain;
    logic [SCAN_W-1:0]      r_scan;
    logic                   r_clr;
    logic [PWR_W-1:0]       r_latest [CHANNELS];
    logic [SUM_W-1:0]       r_sum    [CHANNELS];
    logic [PWR_W-1:0]       r_frame  [CHANNELS];
    logic [SCAN_W-1:0]      r_frame_count;
    logic [GAIN_W-1:0]      r_frame_gain;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [PROD_W-1:0]      r_prod;

    logic                   r_out_valid;
    logic                   r_kind;
    logic [CHAN_W-1:0]      r_channel;
    logic [SEL_W-1:0]       r_mux_select;
    logic [GAIN_W-1:0]      r_gain_bits;
    logic [PWR_W-1:0]       r_average;
    logic [SCAN_W-1:0]      r_total;
    logic                   r_last;

    logic                   in_accept;
    logic                   out_free;
    logic                   out_load;
    logic [CH_W-1:0]        ch_next;
    logic [CH_W-1:0]        idx_next;
    logic [DIV_W-1:0]       div_raw;
    logic [DIV_W-1:0]       div_eff;
    logic                   div_start;
    logic [NUM_W-1:0]       div_dividend;
    logic [DIV_W-1:0]       div_divisor;
    logic                   div_done;
    logic [NUM_W-1:0]       div_quot;
    logic [PWR_W-1:0]       power_sat;
    logic [PWR_W-1:0]       latest_rd;

    assign in_accept = i_in_valid & ~o_in_stall;
    assign out_free  = ~r_out_valid | ~i_out_stall;
    assign out_load  = ((r_state == S_STEP_OUT) || (r_state == S_FRAME_OUT)) && out_free;
    assign ch_next   = (r_ch == CH_LAST) ? '0 : r_ch + 1'b1;
    assign idx_next  = r_idx + 1'b1;
    assign latest_rd = r_latest[r_idx];

    // divisor chosen by the gain of the sampled channel, zero acts as one
    assign div_raw = r_gain[r_ch] ? cfg.divisor_high_gain : cfg.divisor_low_gain;
    assign div_eff = (div_raw == '0) ? DIV_W'(1) : div_raw;

    // shared divider operands: rounded power, or channel sum over scan count
    always_comb begin
        if (r_state == S_RD_GO) begin
            div_dividend = NUM_W'(r_sum[r_idx]);
            div_divisor  = DIV_W'(r_scan);
        end else begin
            div_dividend = NUM_W'(r_prod) + NUM_W'(div_eff >> 1);
            div_divisor  = div_eff;
        end
    end

    assign div_start = (r_state == S_DIV_GO) || (r_state == S_RD_GO);
    assign power_sat = (|div_quot[NUM_W-1:PWR_W]) ? '1 : div_quot[PWR_W-1:0];

    pavg_div #(
        .N_W (NUM_W),
        .D_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // sequencer, channel state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ch          <= '0;
            r_idx         <= '0;
            r_gain        <= '0;
            r_scan        <= '0;
            r_clr         <= 1'b0;
            r_frame_count <= '0;
            r_frame_gain  <= '0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_latest[i] <= '0;
                r_sum[i]    <= '0;
                r_frame[i]  <= '0;
            end
        end else begin
            // new beat loaded, or beat taken downstream
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_sample <= i_adc_sample;
                        if (i_cmd == CMD_READ) begin
                            r_idx   <= '0;
                            r_state <= (r_scan != '0) ? S_RD_GO : S_FRAME_OUT;
                        end else begin
                            r_idx   <= r_ch;
                            r_state <= S_MUL;
                        end
                    end
                end

                S_MUL: begin
                    r_prod  <= PROD_W'(r_sample) * PROD_W'(cfg.scale_numerator);
                    r_state <= S_DIV_GO;
                end

                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end

                // store the power, then step to the next channel
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_latest[r_idx] <= power_sat;
                        r_ch            <= ch_next;
                        r_idx           <= ch_next;
                        r_state         <= S_GAIN;
                    end
                end

                // gain hysteresis on the newly selected channel
                S_GAIN: begin
                    if (!r_gain[r_ch]) begin
                        if (latest_rd < cfg.switch_up_threshold) begin
                            r_gain[r_ch] <= 1'b1;
                        end
                    end else if (latest_rd > cfg.switch_down_threshold) begin
                        r_gain[r_ch] <= 1'b0;
                    end
                    r_state <= (r_ch == '0) ? S_SCAN : S_STEP_OUT;
                end

                // scan closed: count it, and on a fold restart the counter at one and the sums
                S_SCAN: begin
                    if (r_scan == SCAN_FOLD) begin
                        r_scan <= SCAN_W'(1);
                        r_clr  <= 1'b1;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                        r_clr  <= 1'b0;
                    end
                    r_idx   <= '0;
                    r_state <= S_ACC;
                end

                S_ACC: begin
                    r_sum[r_idx] <= (r_clr ? '0 : r_sum[r_idx]) + SUM_W'(latest_rd);
                    if (r_idx == CH_LAST) begin
                        r_state <= S_STEP_OUT;
                    end else begin
                        r_idx <= idx_next;
                    end
                end

                S_STEP_OUT: begin
                    if (out_free) begin
                        r_kind       <= KIND_STEP;
                        r_channel    <= CHAN_W'(r_ch);
                        r_mux_select <= cfg.mux_map[5'(3 * r_ch) +: SEL_W];
                        r_gain_bits  <= r_gain;
                        r_average    <= '0;
                        r_total      <= '0;
                        r_last       <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end

                // averaging: the sum is cleared as the divider takes it
                S_RD_GO: begin
                    r_sum[r_idx] <= '0;
                    r_state      <= S_RD_WAIT;
                end

                S_RD_WAIT: begin
                    if (div_done) begin
                        r_frame[r_idx] <= div_quot[PWR_W-1:0];
                        if (r_idx == CH_LAST) begin
                            r_state <= S_RD_DONE;
                        end else begin
                            r_idx   <= idx_next;
                            r_state <= S_RD_GO;
                        end
                    end
                end

                S_RD_DONE: begin
                    r_frame_count <= r_scan;
                    r_frame_gain  <= r_gain;
                    r_scan        <= '0;
                    r_idx         <= '0;
                    r_state       <= S_FRAME_OUT;
                end

                // one frame beat per channel
                S_FRAME_OUT: begin
                    if (out_free) begin
                        r_kind       <= KIND_FRAME;
                        r_channel    <= CHAN_W'(r_idx);
                        r_mux_select <= '0;
                        r_gain_bits  <= r_frame_gain;
                        r_average    <= r_frame[r_idx];
                        r_total      <= r_frame_count;
                        r_last       <= (r_idx == CH_LAST);
                        if (r_idx == CH_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= idx_next;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_channel       = r_channel;
    assign o_mux_select    = r_mux_select;
    assign o_gain_bits     = r_gain_bits;
    assign o_average_value = r_average;
    assign o_scan_total    = r_total;
    assign o_last          = r_last;

endmodule

// ===== sv/pavg_chk.sv =====
module pavg_chk #(
    parameter int CHANNELS = 8
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_kind,
    input logic [pavg_pkg::CHAN_W-1:0]   o_channel,
    input logic [pavg_pkg::SEL_W-1:0]    o_mux_select,
    input logic [pavg_pkg::GAIN_W-1:0]   o_gain_bits,
    input logic [pavg_pkg::PWR_W-1:0]    o_average_value,
    input logic [pavg_pkg::SCAN_W-1:0]   o_scan_total,
    input logic                          o_last
);
    import pavg_pkg::*;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind)
            && $stable(o_channel) && $stable(o_mux_select) && $stable(o_gain_bits)
            && $stable(o_average_value) && $stable(o_scan_total) && $stable(o_last))
        else $error("stalled beat changed");

    // an accepted item blocks the input while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after accept");

    // step reports are single beats with no frame data
    a_step_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_STEP |->
            o_last && o_average_value == '0 && o_scan_total == '0
            && o_channel < CHANNELS)
        else $error("malformed step report");

    // a frame closes on its highest channel
    a_frame_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_FRAME |->
            o_last == (o_channel == CHAN_W'(CHANNELS - 1)) && o_mux_select == '0)
        else $error("frame beat marking wrong");

endmodule

bind multichannel_autorange_power_averager pavg_chk #(
    .CHANNELS (CHANNELS)
) u_pavg_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_kind          (o_kind),
    .o_channel       (o_channel),
    .o_mux_select    (o_mux_select),
    .o_gain_bits     (o_gain_bits),
    .o_average_value (o_average_value),
    .o_scan_total    (o_scan_total),
    .o_last          (o_last)
);
